>>> src/toce_pkg.sv
// ----------------------------------------------------------------------------
// toce_pkg
// opcode codes, widths and the stage structs shared by the execute core files
// ----------------------------------------------------------------------------
`default_nettype none

package toce_pkg;

   localparam int unsigned DATA_W          = 32;
   localparam int unsigned PC_W            = 12;
   localparam int unsigned REG_IDX_W       = 4;
   localparam int unsigned OP_W            = 5;
   localparam int unsigned SHAMT_W         = 5;
   localparam int unsigned RETURN_IO_INDEX = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MAC  = 5'd2,
      OP_AND  = 5'd3,
      OP_OR   = 5'd4,
      OP_XOR  = 5'd5,
      OP_SLL  = 5'd6,
      OP_SRA  = 5'd7,
      OP_SRL  = 5'd8,
      OP_BEQ  = 5'd9,
      OP_BNE  = 5'd10,
      OP_BLT  = 5'd11,
      OP_BGT  = 5'd12,
      OP_BLE  = 5'd13,
      OP_BGE  = 5'd14,
      OP_JAL  = 5'd15,
      OP_LW   = 5'd16,
      OP_SW   = 5'd17,
      OP_RETI = 5'd18,
      OP_IN   = 5'd19,
      OP_OUT  = 5'd20,
      OP_HALT = 5'd21
   } opcode_type;

   // decoded instruction held in the execute stage
   typedef struct packed {
      opcode_type           opcode;
      logic [REG_IDX_W-1:0] dest_index;
      logic [DATA_W-1:0]    rs_value;
      logic [DATA_W-1:0]    rt_value;
      logic [DATA_W-1:0]    rm_value;
      logic [DATA_W-1:0]    rd_value;
      logic [PC_W-1:0]      current_pc;
   } instr_type;

   // execute result plus the store requests it makes
   typedef struct packed {
      logic                 reg_write;
      logic [DATA_W-1:0]    write_value;
      logic [PC_W-1:0]      next_pc;
      logic                 isr_clear;
      logic                 halted;
      logic                 status;
      logic                 mem_we;
      logic [DATA_W-1:0]    mem_wdata;
      logic                 io_we;
      logic [DATA_W-1:0]    io_wdata;
   } result_type;

endpackage

`default_nettype wire

>>> src/three_operand_cpu_execute_core.sv
// ----------------------------------------------------------------------------
// three_operand_cpu_execute_core
// execute stage of a three-operand 32-bit isa with its own data memory and
// i/o register array
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake          payload
//   req_      in          req_valid/stall    opcode, dest index, four operands, pc
//   rsp_      out         rsp_valid/stall    register write, next pc, flags
//
// one item per cycle sustained unless rsp_stall or the sweep holds it: the accept
// edge issues the memory and i/o reads, and the edge on which the execute stage
// advances registers the result and writes the stores back. the synchronous
// read sets the depth. after reset the data memory is swept to zero, and
// req_stall stays high until the sweep ends; the i/o array clears at once.
// rsp_stall holds the output register; the execute stage still accepts one item
// behind it, so outside the sweep req_stall rises only when both stages are full.
// MEM_DEPTH, IO_COUNT must be powers of two (unchecked); addresses wrap to depth.
// ----------------------------------------------------------------------------
`default_nettype none

module three_operand_cpu_execute_core #(
   parameter int unsigned MEM_DEPTH = 4096,
   parameter int unsigned IO_COUNT  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [toce_pkg::OP_W-1:0]           req_opcode,
   input  wire logic [toce_pkg::REG_IDX_W-1:0]      req_dest_index,
   input  wire logic [toce_pkg::DATA_W-1:0]         req_rs_value,
   input  wire logic [toce_pkg::DATA_W-1:0]         req_rt_value,
   input  wire logic [toce_pkg::DATA_W-1:0]         req_rm_value,
   input  wire logic [toce_pkg::DATA_W-1:0]         req_rd_value,
   input  wire logic [toce_pkg::PC_W-1:0]           req_current_pc,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_reg_write,
   output logic      [toce_pkg::REG_IDX_W-1:0]      rsp_write_index,
   output logic      [toce_pkg::DATA_W-1:0]         rsp_write_value,
   output logic      [toce_pkg::PC_W-1:0]           rsp_next_pc,
   output logic                                     rsp_isr_clear,
   output logic                                     rsp_halted,
   output logic                                     rsp_status
);
   import toce_pkg::*;

   localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);
   localparam int unsigned IO_AW  = $clog2(IO_COUNT);
   localparam logic [IO_AW-1:0] RET_IDX = IO_AW'(RETURN_IO_INDEX);

   // execute stage
   logic                s1_valid_ff, s1_valid_in;
   instr_type           s1_ff, s1_in;
   logic [MEM_AW-1:0]   s1_mem_addr_ff;
   logic [IO_AW-1:0]    s1_io_addr_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_reg_write_ff;
   logic [REG_IDX_W-1:0] rsp_write_index_ff;
   logic [DATA_W-1:0]   rsp_write_value_ff;
   logic [PC_W-1:0]     rsp_next_pc_ff;
   logic                rsp_isr_clear_ff, rsp_halted_ff, rsp_status_ff;

   logic                accept, advance, mem_busy;
   logic [DATA_W-1:0]   addr_sum;
   logic [IO_AW-1:0]    io_rd_addr;
   logic [DATA_W-1:0]   mem_rdata, io_rdata;
   result_type          result;

   // handshake: the stage moves on when the output register is free or drains
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = mem_busy || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   // both stores are addressed by rs + rt; reti reads the return-address word
   assign addr_sum   = req_rs_value + req_rt_value;
   assign io_rd_addr = (opcode_type'(req_opcode) == OP_RETI) ? RET_IDX
                                                             : addr_sum[IO_AW-1:0];

   always_comb begin
      s1_in.opcode     = opcode_type'(req_opcode);
      s1_in.dest_index = req_dest_index;
      s1_in.rs_value   = req_rs_value;
      s1_in.rt_value   = req_rt_value;
      s1_in.rm_value   = req_rm_value;
      s1_in.rd_value   = req_rd_value;
      s1_in.current_pc = req_current_pc;
   end

   always_comb begin
      priority if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff          <= s1_in;
         s1_mem_addr_ff <= addr_sum[MEM_AW-1:0];
         s1_io_addr_ff  <= addr_sum[IO_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_reg_write_ff   <= result.reg_write;
         rsp_write_index_ff <= s1_ff.dest_index;
         rsp_write_value_ff <= result.write_value;
         rsp_next_pc_ff     <= result.next_pc;
         rsp_isr_clear_ff   <= result.isr_clear;
         rsp_halted_ff      <= result.halted;
         rsp_status_ff      <= result.status;
      end
   end

   // reads issue on accept, stores write back as the item leaves the stage
   toce_dmem #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (addr_sum[MEM_AW-1:0]),
      .rd_data (mem_rdata),
      .wr_en   (advance && result.mem_we),
      .wr_addr (s1_mem_addr_ff),
      .wr_data (result.mem_wdata),
      .busy    (mem_busy)
   );

   toce_iomem #(
      .IO_COUNT (IO_COUNT)
   ) u_iomem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (io_rd_addr),
      .rd_data (io_rdata),
      .wr_en   (advance && result.io_we),
      .wr_addr (s1_io_addr_ff),
      .wr_data (result.io_wdata)
   );

   toce_alu u_alu (
      .instr     (s1_ff),
      .mem_rdata (mem_rdata),
      .io_rdata  (io_rdata),
      .result    (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_write   = rsp_reg_write_ff;
   assign rsp_write_index = rsp_write_index_ff;
   assign rsp_write_value = rsp_write_value_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_isr_clear   = rsp_isr_clear_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

>>> src/toce_dmem.sv
// ----------------------------------------------------------------------------
// toce_dmem
// data memory: one read port with registered data, one write port, a clearing
// pass after reset and write-to-read forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module toce_dmem #(
   parameter int unsigned MEM_DEPTH = 4096
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      rd_en,
   input  wire logic [$clog2(MEM_DEPTH)-1:0]              rd_addr,
   output logic      [toce_pkg::DATA_W-1:0]               rd_data,
   input  wire logic                                      wr_en,
   input  wire logic [$clog2(MEM_DEPTH)-1:0]              wr_addr,
   input  wire logic [toce_pkg::DATA_W-1:0]               wr_data,
   output logic                                           busy
);
   import toce_pkg::*;

   localparam int unsigned AW = $clog2(MEM_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

   logic [DATA_W-1:0] mem [MEM_DEPTH];

   logic              clr_busy_ff, clr_busy_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [DATA_W-1:0] q_ff;
   logic              fwd_ff;
   logic [DATA_W-1:0] fwd_data_ff;

   logic              we;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // clearing sweep owns the write port until it is done
   assign we    = clr_busy_ff | wr_en;
   assign waddr = clr_busy_ff ? clr_cnt_ff : wr_addr;
   assign wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read; a same-cycle write to that address wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

>>> src/toce_iomem.sv
// ----------------------------------------------------------------------------
// toce_iomem
// i/o register array: one read port with registered data, one write port,
// per-entry valid bits so reset clears it at once, and forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module toce_iomem #(
   parameter int unsigned IO_COUNT = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      rd_en,
   input  wire logic [$clog2(IO_COUNT)-1:0]               rd_addr,
   output logic      [toce_pkg::DATA_W-1:0]               rd_data,
   input  wire logic                                      wr_en,
   input  wire logic [$clog2(IO_COUNT)-1:0]               wr_addr,
   input  wire logic [toce_pkg::DATA_W-1:0]               wr_data
);
   import toce_pkg::*;

   logic [DATA_W-1:0]   mem [IO_COUNT];
   logic [IO_COUNT-1:0] valid_ff;
   logic [DATA_W-1:0]   q_ff;
   logic                q_valid_ff;
   logic                fwd_ff;
   logic [DATA_W-1:0]   fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         q_valid_ff  <= valid_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   // an entry never written since reset reads as zero
   always_comb begin
      priority if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (q_valid_ff) begin
         rd_data = q_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

`default_nettype wire

>>> src/toce_alu.sv
// ----------------------------------------------------------------------------
// toce_alu
// execute datapath: arithmetic, shifts, branch resolution and load/store data
// ----------------------------------------------------------------------------
`default_nettype none

module toce_alu (
   input  wire toce_pkg::instr_type             instr,
   input  wire logic [toce_pkg::DATA_W-1:0]     mem_rdata,
   input  wire logic [toce_pkg::DATA_W-1:0]     io_rdata,
   output toce_pkg::result_type                 result
);
   import toce_pkg::*;

   logic [PC_W-1:0]    seq_pc;
   logic [PC_W-1:0]    target;
   logic [SHAMT_W-1:0] sh;
   logic [DATA_W-1:0]  product;
   logic               eq, lt;

   assign seq_pc  = instr.current_pc + PC_W'(1);
   assign target  = instr.rm_value[PC_W-1:0];
   assign sh      = instr.rt_value[SHAMT_W-1:0];
   assign product = instr.rs_value * instr.rt_value;
   assign eq      = (instr.rs_value == instr.rt_value);
   assign lt      = ($signed(instr.rs_value) < $signed(instr.rt_value));

   always_comb begin
      result             = '0;
      result.next_pc     = seq_pc;
      result.mem_wdata   = instr.rm_value + instr.rd_value;
      result.io_wdata    = instr.rm_value;
      unique case (instr.opcode)
         OP_ADD: begin
            result.reg_write   = 1'b1;
            result.write_value = instr.rs_value + instr.rt_value + instr.rm_value;
         end
         OP_SUB: begin
            result.reg_write   = 1'b1;
            result.write_value = instr.rs_value - instr.rt_value - instr.rm_value;
         end
         OP_MAC: begin
            result.reg_write   = 1'b1;
            result.write_value = product + instr.rm_value;
         end
         OP_AND: begin
            result.reg_write   = 1'b1;
            result.write_value = instr.rs_value & instr.rt_value & instr.rm_value;
         end
         OP_OR: begin
            result.reg_write   = 1'b1;
            result.write_value = instr.rs_value | instr.rt_value | instr.rm_value;
         end
         OP_XOR: begin
            result.reg_write   = 1'b1;
            result.write_value = instr.rs_value ^ instr.rt_value ^ instr.rm_value;
         end
         OP_SLL: begin
            result.reg_write   = 1'b1;
            result.write_value = instr.rs_value << sh;
         end
         OP_SRA: begin
            result.reg_write   = 1'b1;
            result.write_value = DATA_W'($signed(instr.rs_value) >>> sh);
         end
         OP_SRL: begin
            result.reg_write   = 1'b1;
            result.write_value = instr.rs_value >> sh;
         end
         OP_BEQ: if (eq)        result.next_pc = target;
         OP_BNE: if (!eq)       result.next_pc = target;
         OP_BLT: if (lt)        result.next_pc = target;
         OP_BGT: if (!lt && !eq) result.next_pc = target;
         OP_BLE: if (lt || eq)  result.next_pc = target;
         OP_BGE: if (!lt)       result.next_pc = target;
         OP_JAL: begin
            result.reg_write   = 1'b1;
            result.write_value = DATA_W'(seq_pc);
            result.next_pc     = target;
         end
         OP_LW: begin
            result.reg_write   = 1'b1;
            result.write_value = mem_rdata + instr.rm_value;
         end
         OP_SW: result.mem_we = 1'b1;
         OP_RETI: begin
            result.next_pc   = io_rdata[PC_W-1:0];
            result.isr_clear = 1'b1;
         end
         OP_IN: begin
            result.reg_write   = 1'b1;
            result.write_value = io_rdata;
         end
         OP_OUT: result.io_we = 1'b1;
         OP_HALT: begin
            result.halted  = 1'b1;
            result.next_pc = instr.current_pc;
         end
         default: begin
            // unsupported opcode: flag it, hold the pc, touch nothing
            result.status  = 1'b1;
            result.next_pc = instr.current_pc;
         end
      endcase
   end

endmodule

`default_nettype wire
